FILE: rtl/gdnc_pkg.sv
// gdnc_pkg: constants, types and arithmetic helpers for the Gregorian
// date / day count converter. Used by every module of the block but gdnc_checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gdnc_pkg;

   // field widths
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int COUNT_W = 23;
   localparam int DOY_W   = 9;
   localparam int N_W     = 22;  // day number biased to be positive
   localparam int CENT_W  = 7;
   localparam int MOFS_W  = 9;

   // pipeline depth, input register through result register
   localparam int NSTAGE = 7;

   // opcodes
   localparam logic OP_DATE_TO_COUNT = 1'b0;
   localparam logic OP_COUNT_TO_DATE = 1'b1;

   // calendar constants
   localparam int DAY_BIAS      = 730550;
   localparam int DAYS_PER_400Y = 146097;
   localparam int DAYS_PER_4Y   = 1461;
   localparam int MONTH_NUM     = 153;
   localparam int MONTH_DIV     = 5;
   localparam int CENT_OFFSET   = 497;
   localparam int YEAR_OFFSET   = 489;
   localparam int DAYS_PER_YEAR = 365;
   localparam int CENT_YEARS    = 100;
   localparam int YEAR_MIN      = 1600;
   localparam int YEAR_MAX      = 9999;
   localparam int COUNT_MIN     = -146097;
   localparam int COUNT_MAX     = 2921939;
   localparam int MONTH_FEB     = 2;
   localparam int MONTH_DEC     = 12;
   // january counted as month 13 of the year before
   localparam int JAN_MONTH_OFS = MONTH_NUM * (MONTH_DEC + 2) / MONTH_DIV;

   // reciprocals for the constant divisions, exact over the operand ranges
   localparam int DIV100_SHIFT = 19;
   localparam int DIV100_MUL   = (2 ** DIV100_SHIFT + CENT_YEARS - 1) / CENT_YEARS;
   localparam int DIV5_SHIFT   = 15;
   localparam int DIV5_MUL     = (2 ** DIV5_SHIFT + MONTH_DIV - 1) / MONTH_DIV;
   localparam int MON_SHIFT    = 20;
   localparam int MON_MUL      = (2 ** MON_SHIFT + MONTH_NUM - 1) / MONTH_NUM;
   localparam int C400_SHIFT   = 42;
   localparam longint C400_MUL = ((longint'(1) << C400_SHIFT) + longint'(DAYS_PER_400Y) - 1)
                                 / longint'(DAYS_PER_400Y);
   localparam int C4Y_SHIFT    = 35;
   localparam longint C4Y_MUL  = ((longint'(1) << C4Y_SHIFT) + longint'(DAYS_PER_4Y) - 1)
                                 / longint'(DAYS_PER_4Y);

   typedef struct packed {
      logic [NSTAGE-1:0] load;  // stage k takes the item of stage k-1
   } gdnc_ctrl_type;

   // year / 100 for years below 12800
   function automatic logic [CENT_W-1:0] div100(input logic [YEAR_W-1:0] y);
      logic [26:0] p;
      p = 27'(y) * 27'(DIV100_MUL);
      return p[DIV100_SHIFT+CENT_W-1:DIV100_SHIFT];
   endfunction

   // 153 * mp1 / 5, days before a march-based month
   function automatic logic [MOFS_W-1:0] month_offset(input logic [4:0] mp1);
      logic [11:0] t;
      logic [24:0] p;
      t = 12'(MONTH_NUM) * 12'(mp1);
      p = 25'(t) * 25'(DIV5_MUL);
      return p[DIV5_SHIFT+MOFS_W-1:DIV5_SHIFT];
   endfunction

   // day count of an adjusted year, century, month offset and day, mod 2**23
   function automatic logic [COUNT_W-1:0] date_sum(input logic [YEAR_W-1:0] yp,
                                                   input logic [CENT_W-1:0] c,
                                                   input logic [MOFS_W-1:0] mo,
                                                   input logic [DAY_W-1:0] d);
      logic [24:0] pos;
      logic [24:0] s;
      pos = 25'(DAYS_PER_YEAR) * 25'(yp) + 25'(yp >> 2) + 25'(2) + 25'(c >> 2)
            + 25'(mo) + 25'(d);
      s = pos - 25'(c) - 25'(DAY_BIAS);
      return s[COUNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/gdnc_stage_ctrl.sv
// gdnc_stage_ctrl: per-stage valid bits and load enables for the converter
// pipeline; a stage loads when it is empty or its item moves on.
// Depends on gdnc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gdnc_stage_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output gdnc_pkg::gdnc_ctrl_type ctrl
);
   import gdnc_pkg::*;

   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] valid_in;
   logic [NSTAGE-1:0] ready;

   always_comb begin
      ready[NSTAGE-1] = !valid_ff[NSTAGE-1] || !rsp_stall;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in[0] = ready[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NSTAGE; k++) begin
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[NSTAGE-1];
   assign ctrl.load = ready;

endmodule

`default_nettype wire

FILE: rtl/gdnc_datapath.sv
// gdnc_datapath: seven register stages of the date / day count conversion,
// with the reciprocal multiplies split over the stages.
// Depends on gdnc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gdnc_datapath (
   input  logic                                clock,
   input  gdnc_pkg::gdnc_ctrl_type             ctrl,
   input  logic                                req_opcode,
   input  logic        [gdnc_pkg::YEAR_W-1:0]  req_in_year,
   input  logic        [gdnc_pkg::MONTH_W-1:0] req_in_month,
   input  logic        [gdnc_pkg::DAY_W-1:0]   req_in_day,
   input  logic signed [gdnc_pkg::COUNT_W-1:0] req_in_day_count,
   output logic signed [gdnc_pkg::COUNT_W-1:0] rsp_out_day_count,
   output logic        [gdnc_pkg::YEAR_W-1:0]  rsp_out_year,
   output logic        [gdnc_pkg::MONTH_W-1:0] rsp_out_month,
   output logic        [gdnc_pkg::DAY_W-1:0]   rsp_out_day,
   output logic        [gdnc_pkg::DOY_W-1:0]   rsp_day_of_year,
   output logic                                rsp_range_error
);
   import gdnc_pkg::*;

   // stage 0: input register
   logic                      s0_op_ff;
   logic [YEAR_W-1:0]         s0_year_ff;
   logic [MONTH_W-1:0]        s0_month_ff;
   logic [DAY_W-1:0]          s0_day_ff;
   logic signed [COUNT_W-1:0] s0_cnt_ff;

   // stage 1: century term for both directions
   logic s1_op_ff, s1_op_in, s1_err_ff, s1_err_in;
   logic [YEAR_W-1:0]  s1_yp_ff, s1_yp_in;
   logic [CENT_W-1:0]  s1_c_ff, s1_c_in;
   logic [MOFS_W-1:0]  s1_mo_ff, s1_mo_in;
   logic [DAY_W-1:0]   s1_day_ff, s1_day_in;
   logic [N_W-1:0]     s1_n_ff, s1_n_in;
   logic [COUNT_W-1:0] s1_cnt_ff, s1_cnt_in;

   // stage 2: forward result done, march year found
   logic s2_op_ff, s2_op_in, s2_err_ff, s2_err_in;
   logic [COUNT_W-1:0] s2_dc_ff, s2_dc_in;
   logic [N_W-1:0]     s2_n2_ff, s2_n2_in;
   logic [YEAR_W-1:0]  s2_y_ff, s2_y_in;
   logic [COUNT_W-1:0] s2_cnt_ff, s2_cnt_in;

   // stage 3: day within the march year
   logic s3_op_ff, s3_op_in, s3_err_ff, s3_err_in;
   logic [COUNT_W-1:0] s3_dc_ff, s3_dc_in;
   logic [MOFS_W-1:0]  s3_n3_ff, s3_n3_in;
   logic [YEAR_W-1:0]  s3_y_ff, s3_y_in;
   logic [COUNT_W-1:0] s3_cnt_ff, s3_cnt_in;

   // stage 4: march-based month plus one
   logic s4_op_ff, s4_op_in, s4_err_ff, s4_err_in;
   logic [COUNT_W-1:0] s4_dc_ff, s4_dc_in;
   logic [MONTH_W-1:0] s4_q_ff, s4_q_in;
   logic [MOFS_W-1:0]  s4_n3_ff, s4_n3_in;
   logic [YEAR_W-1:0]  s4_y_ff, s4_y_in;
   logic [COUNT_W-1:0] s4_cnt_ff, s4_cnt_in;

   // stage 5: calendar date, century of the year before
   logic s5_op_ff, s5_op_in, s5_err_ff, s5_err_in;
   logic [COUNT_W-1:0] s5_dc_ff, s5_dc_in;
   logic [YEAR_W-1:0]  s5_y_ff, s5_y_in;
   logic [MONTH_W-1:0] s5_m_ff, s5_m_in;
   logic [DAY_W-1:0]   s5_d_ff, s5_d_in;
   logic [YEAR_W-1:0]  s5_ya_ff, s5_ya_in;
   logic [CENT_W-1:0]  s5_cj_ff, s5_cj_in;
   logic [COUNT_W-1:0] s5_cnt_ff, s5_cnt_in;

   // stage 6: result register
   logic [COUNT_W-1:0] s6_dc_ff, s6_dc_in;
   logic [YEAR_W-1:0]  s6_y_ff, s6_y_in;
   logic [MONTH_W-1:0] s6_m_ff, s6_m_in;
   logic [DAY_W-1:0]   s6_d_ff, s6_d_in;
   logic [DOY_W-1:0]   s6_doy_ff, s6_doy_in;
   logic               s6_err_ff, s6_err_in;

   // ---- stage 0 -> 1
   logic              jf;
   logic [4:0]        mp1;
   logic [YEAR_W-1:0] yp;
   logic [23:0]       n_full;
   logic [23:0]       x1;
   logic [48:0]       p1;
   logic              err0, err1;

   always_comb begin
      err0   = (s0_year_ff < YEAR_W'(YEAR_MIN)) || (s0_year_ff > YEAR_W'(YEAR_MAX));
      err1   = (s0_cnt_ff < COUNT_MIN) || (s0_cnt_ff > COUNT_MAX);
      // january, february and month zero move to the year before
      jf     = s0_month_ff <= MONTH_W'(MONTH_FEB);
      yp     = s0_year_ff - YEAR_W'(jf);
      mp1    = jf ? 5'(s0_month_ff) + 5'(MONTH_DEC + 1) : 5'(s0_month_ff) + 5'd1;
      n_full = 24'(s0_cnt_ff) + 24'(DAY_BIAS);
      x1     = {n_full[N_W-1:0], 2'b00} - 24'(CENT_OFFSET);
      p1     = 49'(x1) * 49'(C400_MUL);

      s1_op_in  = s0_op_ff;
      s1_err_in = s0_op_ff ? err1 : err0;
      s1_yp_in  = yp;
      s1_c_in   = s0_op_ff ? p1[C400_SHIFT+CENT_W-1:C400_SHIFT] : div100(yp);
      s1_mo_in  = month_offset(mp1);
      s1_day_in = s0_day_ff;
      s1_n_in   = n_full[N_W-1:0];
      s1_cnt_in = s0_cnt_ff;
   end

   // ---- stage 1 -> 2
   logic [N_W-1:0] n2;
   logic [23:0]    x2;
   logic [48:0]    p2;

   always_comb begin
      n2 = s1_n_ff + N_W'(s1_c_ff) - N_W'(s1_c_ff >> 2) - N_W'(2);
      x2 = {n2, 2'b00} - 24'(YEAR_OFFSET);
      p2 = 49'(x2) * 49'(C4Y_MUL);

      s2_op_in  = s1_op_ff;
      s2_err_in = s1_err_ff;
      s2_dc_in  = date_sum(s1_yp_ff, s1_c_ff, s1_mo_ff, s1_day_ff);
      s2_n2_in  = n2;
      s2_y_in   = p2[C4Y_SHIFT+YEAR_W-1:C4Y_SHIFT];
      s2_cnt_in = s1_cnt_ff;
   end

   // ---- stage 2 -> 3
   logic [N_W-1:0] n3_full;

   always_comb begin
      n3_full   = s2_n2_ff - N_W'(DAYS_PER_YEAR) * N_W'(s2_y_ff) - N_W'(s2_y_ff >> 2);
      s3_op_in  = s2_op_ff;
      s3_err_in = s2_err_ff;
      s3_dc_in  = s2_dc_ff;
      s3_n3_in  = n3_full[MOFS_W-1:0];
      s3_y_in   = s2_y_ff;
      s3_cnt_in = s2_cnt_ff;
   end

   // ---- stage 3 -> 4
   logic [11:0] x3;
   logic [24:0] p3;

   always_comb begin
      x3 = 12'(MONTH_DIV) * 12'(s3_n3_ff) - 12'd1;
      p3 = 25'(x3) * 25'(MON_MUL);

      s4_op_in  = s3_op_ff;
      s4_err_in = s3_err_ff;
      s4_dc_in  = s3_dc_ff;
      s4_q_in   = p3[MON_SHIFT+MONTH_W-1:MON_SHIFT];
      s4_n3_in  = s3_n3_ff;
      s4_y_in   = s3_y_ff;
      s4_cnt_in = s3_cnt_ff;
   end

   // ---- stage 4 -> 5
   logic [MOFS_W-1:0]  dfull;
   logic [MONTH_W-1:0] m_raw;
   logic               wrap;
   logic [YEAR_W-1:0]  y_fin;
   logic [YEAR_W-1:0]  ya;

   always_comb begin
      dfull = s4_n3_ff - month_offset(5'(s4_q_ff));
      m_raw = s4_q_ff - MONTH_W'(1);
      // months 13 and 14 are january and february of the next year
      wrap  = m_raw > MONTH_W'(MONTH_DEC);
      y_fin = s4_y_ff + YEAR_W'(wrap);
      ya    = s4_y_ff + YEAR_W'(wrap) - YEAR_W'(1);

      s5_op_in  = s4_op_ff;
      s5_err_in = s4_err_ff;
      s5_dc_in  = s4_dc_ff;
      s5_y_in   = y_fin;
      s5_m_in   = wrap ? m_raw - MONTH_W'(MONTH_DEC) : m_raw;
      s5_d_in   = dfull[DAY_W-1:0];
      s5_ya_in  = ya;
      s5_cj_in  = div100(ya);
      s5_cnt_in = s4_cnt_ff;
   end

   // ---- stage 5 -> 6
   logic [COUNT_W-1:0] jan1;
   logic [COUNT_W-1:0] diff;
   logic               fwd_ok, inv_ok;

   always_comb begin
      jan1   = date_sum(s5_ya_ff, s5_cj_ff, MOFS_W'(JAN_MONTH_OFS), DAY_W'(1));
      diff   = s5_cnt_ff - jan1;
      fwd_ok = !s5_err_ff && !s5_op_ff;
      inv_ok = !s5_err_ff && s5_op_ff;

      s6_err_in = s5_err_ff;
      s6_dc_in  = fwd_ok ? s5_dc_ff : '0;
      s6_y_in   = inv_ok ? s5_y_ff : '0;
      s6_m_in   = inv_ok ? s5_m_ff : '0;
      s6_d_in   = inv_ok ? s5_d_ff : '0;
      s6_doy_in = inv_ok ? diff[DOY_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         s0_op_ff    <= req_opcode;
         s0_year_ff  <= req_in_year;
         s0_month_ff <= req_in_month;
         s0_day_ff   <= req_in_day;
         s0_cnt_ff   <= req_in_day_count;
      end
      if (ctrl.load[1]) begin
         s1_op_ff  <= s1_op_in;
         s1_err_ff <= s1_err_in;
         s1_yp_ff  <= s1_yp_in;
         s1_c_ff   <= s1_c_in;
         s1_mo_ff  <= s1_mo_in;
         s1_day_ff <= s1_day_in;
         s1_n_ff   <= s1_n_in;
         s1_cnt_ff <= s1_cnt_in;
      end
      if (ctrl.load[2]) begin
         s2_op_ff  <= s2_op_in;
         s2_err_ff <= s2_err_in;
         s2_dc_ff  <= s2_dc_in;
         s2_n2_ff  <= s2_n2_in;
         s2_y_ff   <= s2_y_in;
         s2_cnt_ff <= s2_cnt_in;
      end
      if (ctrl.load[3]) begin
         s3_op_ff  <= s3_op_in;
         s3_err_ff <= s3_err_in;
         s3_dc_ff  <= s3_dc_in;
         s3_n3_ff  <= s3_n3_in;
         s3_y_ff   <= s3_y_in;
         s3_cnt_ff <= s3_cnt_in;
      end
      if (ctrl.load[4]) begin
         s4_op_ff  <= s4_op_in;
         s4_err_ff <= s4_err_in;
         s4_dc_ff  <= s4_dc_in;
         s4_q_ff   <= s4_q_in;
         s4_n3_ff  <= s4_n3_in;
         s4_y_ff   <= s4_y_in;
         s4_cnt_ff <= s4_cnt_in;
      end
      if (ctrl.load[5]) begin
         s5_op_ff  <= s5_op_in;
         s5_err_ff <= s5_err_in;
         s5_dc_ff  <= s5_dc_in;
         s5_y_ff   <= s5_y_in;
         s5_m_ff   <= s5_m_in;
         s5_d_ff   <= s5_d_in;
         s5_ya_ff  <= s5_ya_in;
         s5_cj_ff  <= s5_cj_in;
         s5_cnt_ff <= s5_cnt_in;
      end
      if (ctrl.load[6]) begin
         s6_err_ff <= s6_err_in;
         s6_dc_ff  <= s6_dc_in;
         s6_y_ff   <= s6_y_in;
         s6_m_ff   <= s6_m_in;
         s6_d_ff   <= s6_d_in;
         s6_doy_ff <= s6_doy_in;
      end
   end

   assign rsp_out_day_count = $signed(s6_dc_ff);
   assign rsp_out_year      = s6_y_ff;
   assign rsp_out_month     = s6_m_ff;
   assign rsp_out_day       = s6_d_ff;
   assign rsp_day_of_year   = s6_doy_ff;
   assign rsp_range_error   = s6_err_ff;

endmodule

`default_nettype wire

FILE: rtl/gregorian_day_number_convert_top.sv
// gregorian_day_number_convert_top: Gregorian date <-> day count converter,
// top level. Instantiates gdnc_stage_ctrl and gdnc_datapath; uses gdnc_pkg.
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_stall  opcode, year, month, day, day count
//   rsp       out         rsp_valid / rsp_stall  day count, date, day of year, error
//
// One item per cycle sustained while rsp is not stalled; each item passes one
// register transfer at a time from the input stage to the result stage, the depth
// set by splitting the reciprocal multiplies over seven registers.
// Reset (synchronous) empties the pipeline; no clearing pass.
// A stall on rsp fills empty stages first; req_stall rises only when every
// stage holds an item.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_day_number_convert_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_opcode,
   input  logic        [gdnc_pkg::YEAR_W-1:0]  req_in_year,
   input  logic        [gdnc_pkg::MONTH_W-1:0] req_in_month,
   input  logic        [gdnc_pkg::DAY_W-1:0]   req_in_day,
   input  logic signed [gdnc_pkg::COUNT_W-1:0] req_in_day_count,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [gdnc_pkg::COUNT_W-1:0] rsp_out_day_count,
   output logic        [gdnc_pkg::YEAR_W-1:0]  rsp_out_year,
   output logic        [gdnc_pkg::MONTH_W-1:0] rsp_out_month,
   output logic        [gdnc_pkg::DAY_W-1:0]   rsp_out_day,
   output logic        [gdnc_pkg::DOY_W-1:0]   rsp_day_of_year,
   output logic                                rsp_range_error
);
   import gdnc_pkg::*;

   gdnc_ctrl_type ctrl;

   gdnc_stage_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl)
   );

   gdnc_datapath u_datapath (
      .clock             (clock),
      .ctrl              (ctrl),
      .req_opcode        (req_opcode),
      .req_in_year       (req_in_year),
      .req_in_month      (req_in_month),
      .req_in_day        (req_in_day),
      .req_in_day_count  (req_in_day_count),
      .rsp_out_day_count (rsp_out_day_count),
      .rsp_out_year      (rsp_out_year),
      .rsp_out_month     (rsp_out_month),
      .rsp_out_day       (rsp_out_day),
      .rsp_day_of_year   (rsp_day_of_year),
      .rsp_range_error   (rsp_range_error)
   );

endmodule

`default_nettype wire

FILE: rtl/gdnc_checker.sv
// gdnc_checker: port-level assertions for gregorian_day_number_convert_top,
// bound to the top level below. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module gdnc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [22:0] rsp_out_day_count,
   input logic        [13:0] rsp_out_year,
   input logic        [3:0]  rsp_out_month,
   input logic        [4:0]  rsp_out_day,
   input logic        [8:0]  rsp_day_of_year,
   input logic               rsp_range_error
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_day_count)
         && $stable(rsp_out_year) && $stable(rsp_out_month) && $stable(rsp_out_day)
         && $stable(rsp_day_of_year) && $stable(rsp_range_error))
      else $error("stalled result item changed");

   // an out-of-span item carries nothing but the flag
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> rsp_out_day_count == 0 && rsp_out_year == 0
         && rsp_out_month == 0 && rsp_out_day == 0 && rsp_day_of_year == 0)
      else $error("range error item has nonzero fields");

   // a date result lies in span and carries no day count
   a_date_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_year != 0 |-> rsp_out_day_count == 0
         && rsp_out_year >= 14'd1600 && rsp_out_year <= 14'd9999
         && rsp_out_month >= 4'd1 && rsp_out_month <= 4'd12)
      else $error("date result out of span");

   // reset leaves the pipeline empty and open
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // with no result waiting the input is never held off
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result stage");

endmodule

bind gregorian_day_number_convert_top gdnc_checker u_gdnc_checker (.*);

`default_nettype wire

FILE: dv/gregorian_day_number_convert_checker.sv
`timescale 1ns / 1ps
// gregorian_day_number_convert_checker: watches the req and rsp channels of the
// date / day count converter, predicts each result and compares it field by field.
// Depends on gdnc_pkg for the field widths and opcodes only.

module gregorian_day_number_convert_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_opcode,
   input  logic        [gdnc_pkg::YEAR_W-1:0]  req_in_year,
   input  logic        [gdnc_pkg::MONTH_W-1:0] req_in_month,
   input  logic        [gdnc_pkg::DAY_W-1:0]   req_in_day,
   input  logic signed [gdnc_pkg::COUNT_W-1:0] req_in_day_count,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [gdnc_pkg::COUNT_W-1:0] rsp_out_day_count,
   input  logic        [gdnc_pkg::YEAR_W-1:0]  rsp_out_year,
   input  logic        [gdnc_pkg::MONTH_W-1:0] rsp_out_month,
   input  logic        [gdnc_pkg::DAY_W-1:0]   rsp_out_day,
   input  logic        [gdnc_pkg::DOY_W-1:0]   rsp_day_of_year,
   input  logic                                rsp_range_error,
   output int                                  mismatches,
   output int                                  pending
);

   localparam int YEAR_BITS  = gdnc_pkg::YEAR_W;
   localparam int MONTH_BITS = gdnc_pkg::MONTH_W;
   localparam int DAY_BITS   = gdnc_pkg::DAY_W;
   localparam int COUNT_BITS = gdnc_pkg::COUNT_W;
   localparam int DOY_BITS   = gdnc_pkg::DOY_W;

   // calendar arithmetic, day 0 is 2000-01-01
   localparam longint EPOCH_BIAS  = 730550;
   localparam longint ERA_DAYS    = 146097;
   localparam longint QUAD_DAYS   = 1461;
   localparam longint MONTH_SPAN  = 153;
   localparam longint ERA_SHIFT   = 497;
   localparam longint QUAD_SHIFT  = 489;
   localparam longint YEAR_DAYS   = 365;
   localparam longint FIRST_YEAR  = 1600;
   localparam longint LAST_YEAR   = 9999;
   localparam longint FIRST_COUNT = -146097;
   localparam longint LAST_COUNT  = 2921939;

   typedef struct packed {
      logic [COUNT_BITS-1:0] day_count;
      logic [YEAR_BITS-1:0]  year;
      logic [MONTH_BITS-1:0] month;
      logic [DAY_BITS-1:0]   mday;
      logic [DOY_BITS-1:0]   yday;
      logic                  range_err;
   } calendar_result_type;

   calendar_result_type expected_q[$];
   calendar_result_type want;
   int                  fail_count = 0;
   int                  rsp_index = 0;

   // january and february count as months 13 and 14 of the year before
   function automatic longint civil_day_count(input longint y, input longint m,
                                              input longint d);
      longint cent;
      if (m <= 2) begin
         m += 12;
         y -= 1;
      end
      cent = y / 100;
      return YEAR_DAYS * y + y / 4 + (2 - cent + cent / 4) + MONTH_SPAN * (m + 1) / 5
             + d - EPOCH_BIAS;
   endfunction

   function automatic calendar_result_type predict_conversion(
         input logic op, input logic [YEAR_BITS-1:0] yr, input logic [MONTH_BITS-1:0] mon,
         input logic [DAY_BITS-1:0] dd, input logic signed [COUNT_BITS-1:0] cnt_in);
      calendar_result_type r;
      longint year_in;
      longint cnt;
      longint n;
      longint cent;
      longint y;
      longint m;
      r = '0;
      year_in = yr;
      cnt = cnt_in;
      if (op != gdnc_pkg::OP_COUNT_TO_DATE) begin
         if (year_in < FIRST_YEAR || year_in > LAST_YEAR)
            r.range_err = 1'b1;
         else
            r.day_count = COUNT_BITS'(civil_day_count(year_in, longint'(mon), longint'(dd)));
         return r;
      end
      if (cnt < FIRST_COUNT || cnt > LAST_COUNT) begin
         r.range_err = 1'b1;
         return r;
      end
      n = cnt + EPOCH_BIAS;
      cent = (4 * n - ERA_SHIFT) / ERA_DAYS;
      n -= 2 - cent + cent / 4;
      y = (4 * n - QUAD_SHIFT) / QUAD_DAYS;
      n -= YEAR_DAYS * y + y / 4;
      m = (5 * n - 1) / MONTH_SPAN - 1;
      n -= MONTH_SPAN * (m + 1) / 5;
      if (m > 12) begin
         m -= 12;
         y += 1;
      end
      r.year = YEAR_BITS'(y);
      r.month = MONTH_BITS'(m);
      r.mday = DAY_BITS'(n);
      r.yday = DOY_BITS'(cnt - civil_day_count(y, 1, 1));
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t: result %0d: %s", $time, rsp_index, what);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] exp_val);
      if (got !== exp_val)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, exp_val));
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_q.push_back(predict_conversion(req_opcode, req_in_year, req_in_month,
                                                    req_in_day, req_in_day_count));
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               report_mismatch("result with no item outstanding");
            end else begin
               want = expected_q.pop_front();
               check_field("day count", 32'($unsigned(rsp_out_day_count)),
                           32'(want.day_count));
               check_field("year", 32'(rsp_out_year), 32'(want.year));
               check_field("month", 32'(rsp_out_month), 32'(want.month));
               check_field("day", 32'(rsp_out_day), 32'(want.mday));
               check_field("day of year", 32'(rsp_day_of_year), 32'(want.yday));
               check_field("range error", 32'(rsp_range_error), 32'(want.range_err));
            end
            rsp_index++;
         end
      end
      pending <= expected_q.size();
      mismatches <= fail_count;
   end

endmodule

FILE: dv/gregorian_day_number_convert_top_test.sv
`timescale 1ns / 1ps
// gregorian_day_number_convert_top_test: drives date and day count items into the
// converter with random idling on both channels and gives the verdict.
// Depends on gdnc_pkg, gregorian_day_number_convert_top and the checker module.

module gregorian_day_number_convert_top_test;

   localparam int YEAR_BITS  = gdnc_pkg::YEAR_W;
   localparam int MONTH_BITS = gdnc_pkg::MONTH_W;
   localparam int DAY_BITS   = gdnc_pkg::DAY_W;
   localparam int COUNT_BITS = gdnc_pkg::COUNT_W;

   localparam int RANDOM_ITEMS = 1150;
   localparam int CALM_FROM    = 1000;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic                          req_opcode;
   logic        [YEAR_BITS-1:0]   req_in_year;
   logic        [MONTH_BITS-1:0]  req_in_month;
   logic        [DAY_BITS-1:0]    req_in_day;
   logic signed [COUNT_BITS-1:0]  req_in_day_count;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [COUNT_BITS-1:0]  rsp_out_day_count;
   logic        [YEAR_BITS-1:0]   rsp_out_year;
   logic        [MONTH_BITS-1:0]  rsp_out_month;
   logic        [DAY_BITS-1:0]    rsp_out_day;
   logic        [gdnc_pkg::DOY_W-1:0] rsp_day_of_year;
   logic                          rsp_range_error;
   int                            mismatches;
   int                            pending;
   int                            idle_pct = 0;
   int                            stall_pct = 0;

   gregorian_day_number_convert_top uut (.*);

   gregorian_day_number_convert_checker conv_check (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #200000;
      $display("gregorian_day_number_convert_top_test failed");
      $finish;
   end

   // stall bursts on the result side
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_pct > 0 && $urandom_range(1, 100) <= stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_item(input logic op, input logic [YEAR_BITS-1:0] yr,
                            input logic [MONTH_BITS-1:0] mon, input logic [DAY_BITS-1:0] dd,
                            input logic signed [COUNT_BITS-1:0] cnt);
      if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_in_year <= yr;
      req_in_month <= mon;
      req_in_day <= dd;
      req_in_day_count <= cnt;
      do @(posedge clock); while (req_stall);
   endtask

   // unused fields carry random bits
   task automatic to_count(input int y, input int m, input int d);
      send_item(gdnc_pkg::OP_DATE_TO_COUNT, YEAR_BITS'(y), MONTH_BITS'(m), DAY_BITS'(d),
                COUNT_BITS'($urandom));
   endtask

   task automatic to_date(input int cnt);
      send_item(gdnc_pkg::OP_COUNT_TO_DATE, YEAR_BITS'($urandom), MONTH_BITS'($urandom),
                DAY_BITS'($urandom), COUNT_BITS'(cnt));
   endtask

   initial begin
      int i;
      int edge_cnt;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= gdnc_pkg::OP_DATE_TO_COUNT;
      req_in_year <= '0;
      req_in_month <= '0;
      req_in_day <= '0;
      req_in_day_count <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // epoch, span limits, leap day, years out of span, unchecked month and day
      to_count(2000, 1, 1);
      to_count(1600, 1, 1);
      to_count(1600, 3, 1);
      to_count(9999, 12, 31);
      to_count(2000, 2, 29);
      to_count(1900, 3, 1);
      to_count(1599, 6, 15);
      to_count(10000, 1, 1);
      to_count(0, 0, 0);
      to_count(16383, 15, 31);
      to_count(2024, 0, 0);
      to_count(2024, 13, 31);
      to_count(9999, 15, 31);
      to_count(1600, 0, 1);
      to_date(0);
      to_date(gdnc_pkg::COUNT_MIN);
      to_date(gdnc_pkg::COUNT_MAX);
      to_date(gdnc_pkg::COUNT_MIN - 1);
      to_date(gdnc_pkg::COUNT_MAX + 1);
      to_date(-(1 << (COUNT_BITS - 1)));
      to_date((1 << (COUNT_BITS - 1)) - 1);
      to_date(59);
      to_date(365);
      to_date(-1);

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 64 == 0) begin
            idle_pct = 20 * $urandom_range(0, 3);
            stall_pct = 20 * $urandom_range(0, 3);
         end
         if (i >= CALM_FROM) begin
            idle_pct = 0;
            stall_pct = 0;
         end
         case ($urandom_range(0, 9))
            0, 1, 2: to_count($urandom_range(gdnc_pkg::YEAR_MIN, gdnc_pkg::YEAR_MAX),
                              $urandom_range(1, 12), $urandom_range(1, 31));
            3: to_count($urandom_range(gdnc_pkg::YEAR_MIN, gdnc_pkg::YEAR_MAX),
                        $urandom_range(0, 15), $urandom_range(0, 31));
            4: to_count($urandom_range(0, (1 << YEAR_BITS) - 1), $urandom_range(0, 15),
                        $urandom_range(0, 31));
            5, 6, 7: to_date(int'($urandom_range(0, gdnc_pkg::COUNT_MAX - gdnc_pkg::COUNT_MIN))
                             + gdnc_pkg::COUNT_MIN);
            8: begin
               // just around either end of the span
               edge_cnt = $urandom_range(0, 1) ? gdnc_pkg::COUNT_MIN : gdnc_pkg::COUNT_MAX;
               to_date(edge_cnt + int'($urandom_range(0, 8)) - 4);
            end
            default: to_date(int'($urandom));
         endcase
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (gdnc_pkg::NSTAGE + 4) @(posedge clock);
      if (mismatches == 0)
         $display("gregorian_day_number_convert_top_test passed");
      else
         $display("gregorian_day_number_convert_top_test failed");
      $finish;
   end

endmodule
